@@ sv/aqi_pkg.sv @@
package aqi_pkg;

    // Field and datapath widths
    localparam int CONC_W      = 16;
    localparam int SEL_W       = 2;
    localparam int IDX_W       = 13;
    localparam int DIFF_W      = 10;
    localparam int OFS_W       = 13;
    localparam int PROD_W      = DIFF_W + OFS_W;
    localparam int RECIP_W     = 30;
    localparam int RECIP_SHIFT = 36;
    localparam int QUOT_W      = 10;
    localparam int NUM_POLL    = 3;
    localparam int NUM_SEG     = 7;
    localparam int SEG_W       = 3;
    localparam int POLL_W      = 2;
    localparam logic [IDX_W-1:0] IDX_MAX = 13'd5000;

    // Pollutant selector codes
    localparam logic [SEL_W-1:0] SEL_PM25     = 2'd0;
    localparam logic [SEL_W-1:0] SEL_PM10     = 2'd1;
    localparam logic [SEL_W-1:0] SEL_NO2      = 2'd2;
    localparam logic [SEL_W-1:0] SEL_RESERVED = 2'd3;

    // Segment bounds, tenths of a concentration unit
    localparam logic [CONC_W-1:0] CONC_LO [NUM_POLL][NUM_SEG] = '{
        '{16'd0, 16'd121, 16'd355,  16'd555,  16'd1505, 16'd2505,  16'd3505},
        '{16'd0, 16'd550, 16'd1550, 16'd2550, 16'd3550, 16'd4250,  16'd5050},
        '{16'd0, 16'd540, 16'd1010, 16'd3610, 16'd6500, 16'd12500, 16'd16500}
    };

    localparam logic [CONC_W-1:0] CONC_HI [NUM_POLL][NUM_SEG] = '{
        '{16'd120, 16'd354,  16'd554,  16'd1504, 16'd2504,  16'd3504,  16'd5004},
        '{16'd540, 16'd1540, 16'd2540, 16'd3540, 16'd4240,  16'd5040,  16'd6040},
        '{16'd530, 16'd1000, 16'd3600, 16'd6490, 16'd12490, 16'd16490, 16'd20490}
    };

    // Index bounds in tenths, shared by all pollutants
    localparam logic [IDX_W-1:0] IDX_LO [NUM_SEG] = '{
        13'd0, 13'd510, 13'd1010, 13'd1510, 13'd2010, 13'd3010, 13'd4010
    };

    localparam logic [DIFF_W-1:0] IDX_DIFF [NUM_SEG] = '{
        10'd500, 10'd490, 10'd490, 10'd490, 10'd990, 10'd990, 10'd990
    };

    // Rounded-up reciprocals of the segment spans, scaled by 2^RECIP_SHIFT.
    // Product of span and the largest product stays below 2^RECIP_SHIFT,
    // so (prod * recip) >> RECIP_SHIFT is the exact floor quotient.
    localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] RECIP [NUM_POLL][NUM_SEG] = '{
        '{30'((RECIP_ONE + 64'd119)  / 64'd120),
          30'((RECIP_ONE + 64'd232)  / 64'd233),
          30'((RECIP_ONE + 64'd198)  / 64'd199),
          30'((RECIP_ONE + 64'd948)  / 64'd949),
          30'((RECIP_ONE + 64'd998)  / 64'd999),
          30'((RECIP_ONE + 64'd998)  / 64'd999),
          30'((RECIP_ONE + 64'd1498) / 64'd1499)},
        '{30'((RECIP_ONE + 64'd539)  / 64'd540),
          30'((RECIP_ONE + 64'd989)  / 64'd990),
          30'((RECIP_ONE + 64'd989)  / 64'd990),
          30'((RECIP_ONE + 64'd989)  / 64'd990),
          30'((RECIP_ONE + 64'd689)  / 64'd690),
          30'((RECIP_ONE + 64'd789)  / 64'd790),
          30'((RECIP_ONE + 64'd989)  / 64'd990)},
        '{30'((RECIP_ONE + 64'd529)  / 64'd530),
          30'((RECIP_ONE + 64'd459)  / 64'd460),
          30'((RECIP_ONE + 64'd2589) / 64'd2590),
          30'((RECIP_ONE + 64'd2879) / 64'd2880),
          30'((RECIP_ONE + 64'd5989) / 64'd5990),
          30'((RECIP_ONE + 64'd3989) / 64'd3990),
          30'((RECIP_ONE + 64'd3989) / 64'd3990)}
    };

    // Channel payloads
    typedef struct packed {
        logic [SEL_W-1:0]  req_type;
        logic [CONC_W-1:0] concentration;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] index_tenths;
        logic             out_of_range;
    } rsp_t;

    // Stage payloads
    typedef struct packed {
        logic [POLL_W-1:0] poll;
        logic [SEG_W-1:0]  seg;
        logic [PROD_W-1:0] prod;
        logic              oor;
    } seg_res_t;

    typedef struct packed {
        logic [SEG_W-1:0]  seg;
        logic [QUOT_W-1:0] quot;
        logic              oor;
    } quot_res_t;

endpackage

@@ sv/aqi_seg.sv @@
module aqi_seg
    import aqi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  req_t     up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output seg_res_t dn_data
);

    logic              valid_reg;
    seg_res_t          data_reg;
    seg_res_t          data_next;
    logic              sel_ok;
    logic [POLL_W-1:0] poll;
    logic [SEG_W-1:0]  seg;
    logic              hit;
    logic [CONC_W-1:0] lo;
    logic [CONC_W-1:0] diff;
    logic [OFS_W-1:0]  ofs;

    // Segment search: seven parallel compares, lowest matching segment wins
    always_comb
    begin
        sel_ok = (up_data.req_type != SEL_RESERVED);
        poll   = sel_ok ? up_data.req_type : SEL_PM25;
        seg    = '0;
        hit    = 1'b0;
        for (int k = NUM_SEG - 1; k >= 0; k--)
        begin
            if (up_data.concentration <= CONC_HI[poll][k])
            begin
                seg = SEG_W'(k);
                hit = 1'b1;
            end
        end
    end

    // Offset into the segment, gap values clamp to the low bound
    always_comb
    begin
        lo   = CONC_LO[poll][seg];
        diff = up_data.concentration - lo;
        ofs  = (up_data.concentration < lo) ? '0 : diff[OFS_W-1:0];
    end

    // Scaled offset; out of range yields a zero index downstream
    always_comb
    begin
        data_next.oor  = !(sel_ok && hit);
        data_next.poll = data_next.oor ? SEL_PM25 : poll;
        data_next.seg  = data_next.oor ? '0 : seg;
        data_next.prod = data_next.oor ? '0 : IDX_DIFF[seg] * ofs;
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ sv/aqi_scale.sv @@
module aqi_scale
    import aqi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  seg_res_t  up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output quot_res_t dn_data
);

    logic                      valid_reg;
    quot_res_t                 data_reg;
    quot_res_t                 data_next;
    logic [PROD_W+RECIP_W-1:0] scaled;

    // Divide by the span through its reciprocal
    always_comb
    begin
        scaled         = up_data.prod * RECIP[up_data.poll][up_data.seg];
        data_next.seg  = up_data.seg;
        data_next.quot = scaled[RECIP_SHIFT +: QUOT_W];
        data_next.oor  = up_data.oor;
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ sv/air_quality_index_calc_unit.sv @@
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_ready  req_t: req_type, concentration
// rsp      out  rsp_valid / rsp_ready  rsp_t: index_tenths, out_of_range
//
// One request per cycle sustained while rsp_ready is held high; a request
// passes the input register, segment search, reciprocal multiply and the
// output add into the result register, and its result is presented from there.
// Each stage holds its item while the stage after it is full and stalled,
// so a waiting result only blocks once all stages are full.
// Reset clears the valid bits only; the data registers are not reset.
module air_quality_index_calc_unit
    import aqi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic      in_valid_reg;
    req_t      in_data_reg;
    logic      seg_ready;
    logic      seg_valid;
    seg_res_t  seg_data;
    logic      scale_ready;
    logic      quot_valid;
    quot_res_t quot_data;
    logic      out_ready;
    logic      out_valid_reg;
    rsp_t      out_data_reg;
    rsp_t      out_data_next;

    // Input register
    assign req_ready = !in_valid_reg || seg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_data_reg <= req;
        end
    end

    aqi_seg u_seg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid_reg),
        .up_ready (seg_ready),
        .up_data  (in_data_reg),
        .dn_valid (seg_valid),
        .dn_ready (scale_ready),
        .dn_data  (seg_data)
    );

    aqi_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (seg_valid),
        .up_ready (scale_ready),
        .up_data  (seg_data),
        .dn_valid (quot_valid),
        .dn_ready (out_ready),
        .dn_data  (quot_data)
    );

    // Output add: segment base index plus interpolated part
    always_comb
    begin
        out_data_next.index_tenths = IDX_LO[quot_data.seg] + IDX_W'(quot_data.quot);
        out_data_next.out_of_range = quot_data.oor;
    end

    assign out_ready = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= quot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quot_valid && out_ready)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // Index never exceeds the top of the scale
    a_idx_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.index_tenths <= IDX_MAX))
        else $error("index above 5000");

    // Out-of-range results carry a zero index
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.out_of_range) |-> (rsp.index_tenths == '0))
        else $error("out-of-range result with nonzero index");

    // Backpressure reaches the request side only with every stage full
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (in_valid_reg && seg_valid && quot_valid && rsp_valid))
        else $error("request stalled with an empty stage");

    // In-range segment product stays within the widest span times its slope
    a_prod_max: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_valid && scale_ready && (seg_data.oor == 1'b0)) |->
            (seg_data.prod <= PROD_W'(990 * 5990)))
        else $error("segment product out of bounds");

endmodule
